@@ design/rer_pkg.sv @@
// Package for the ray/ellipse range unit.
// Holds the transfer structs, datapath widths and the CORDIC arctangent table.
// No dependencies.
package rer_pkg;

    localparam int ANGLE_BITS_DEF = 16;
    localparam int CORDIC_STEPS   = 24;
    localparam int CORDIC_XW      = 34;
    localparam int CORDIC_ZW      = 33;
    localparam int SQRT_STEPS     = 32;
    localparam int SQRT_REM_W     = 34;
    localparam int DIV_STEPS      = 24;
    localparam int NUM_W          = 89;
    localparam int TRIG_W         = 17;

    localparam logic signed [CORDIC_XW-1:0] CORDIC_START = 34'sd652032874;
    localparam logic [23:0] RANGE_MAX = 24'hFFFFFF;

    typedef struct packed {
        logic [15:0]        beam_angle;
        logic [15:0]        axis_one;
        logic [15:0]        axis_two;
        logic signed [23:0] centre_x;
        logic signed [23:0] centre_y;
    } in_t;

    typedef struct packed {
        logic        hit;
        logic [23:0] range;
    } out_t;

    // Arctangent of 2^-i, scaled so that a quarter turn is 2^30
    function automatic logic signed [CORDIC_ZW-1:0] atan_val(input int idx);
        logic signed [CORDIC_ZW-1:0] r;
        case (idx)
            0:  r = 33'sd536870912;
            1:  r = 33'sd316933406;
            2:  r = 33'sd167458907;
            3:  r = 33'sd85004756;
            4:  r = 33'sd42667331;
            5:  r = 33'sd21354465;
            6:  r = 33'sd10679838;
            7:  r = 33'sd5340245;
            8:  r = 33'sd2670163;
            9:  r = 33'sd1335087;
            10: r = 33'sd667544;
            11: r = 33'sd333772;
            12: r = 33'sd166886;
            13: r = 33'sd83443;
            14: r = 33'sd41722;
            15: r = 33'sd20861;
            16: r = 33'sd10430;
            17: r = 33'sd5215;
            18: r = 33'sd2608;
            19: r = 33'sd1304;
            20: r = 33'sd652;
            21: r = 33'sd326;
            22: r = 33'sd163;
            23: r = 33'sd81;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

@@ design/ray_ellipse_range_unit.sv @@
// Top level of the ray/ellipse range unit: CORDIC, product stages, square root and divider chains.
// Depends on rer_pkg, rer_cordic_cell, rer_sqrt_cell and rer_div_cell.
//
// The unit takes one item in every clock cycle and never raises busy; each result appears on
// result with done high for one cycle, in order, after passing through the input register, 24
// CORDIC cells, six product and compare stages, 32 square root cells, two stages for the root
// product and range numerator, 24 divider cells and the output register. Nothing can hold
// results back, so the receiver must take every done cycle.
module ray_ellipse_range_unit #(
    parameter int ANGLE_BITS = rer_pkg::ANGLE_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  rer_pkg::in_t  item,
    output logic          done,
    output rer_pkg::out_t result
);

    localparam int XW      = rer_pkg::CORDIC_XW;
    localparam int ZW      = rer_pkg::CORDIC_ZW;
    localparam int NCS     = rer_pkg::CORDIC_STEPS;
    localparam int NSQ     = rer_pkg::SQRT_STEPS;
    localparam int NDV     = rer_pkg::DIV_STEPS;
    localparam int NW      = rer_pkg::NUM_W;
    localparam int TW      = rer_pkg::TRIG_W;
    localparam int CTAG_W  = 2 + 16 + 16 + 24 + 24;
    localparam int STAG_W  = 1 + 64 + 74 + 32;
    localparam int DTAG_W  = 2;
    localparam int LAT     = 1 + NCS + 6 + NSQ + 2 + NDV + 1;
    localparam logic [31:0] ANG_MASK = 32'((64'd1 << ANGLE_BITS) - 64'd1);

    // Scale a CORDIC result to 2^15 with rounding and clamp to one
    function automatic logic signed [TW-1:0] to_trig(input logic signed [XW-1:0] v);
        logic signed [XW-1:0] t;
        t = (v + 34'sd16384) >>> 15;
        if (t > 34'sd32768)
            t = 34'sd32768;
        if (t < -34'sd32768)
            t = -34'sd32768;
        return TW'(t);
    endfunction

    assign busy = 1'b0;

    // ---------------- input stage ----------------
    logic           s0_vld_reg;
    logic [31:0]    phase;
    logic [CTAG_W-1:0] s0_tag_reg;
    logic signed [ZW-1:0] s0_z_reg;

    assign phase = ({16'd0, item.beam_angle} & ANG_MASK) << (32 - ANGLE_BITS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_vld_reg <= 1'b0;
        else
            s0_vld_reg <= start & ~busy;
    end

    always_ff @(posedge clk)
    begin
        s0_z_reg   <= $signed({3'b000, phase[29:0]});
        s0_tag_reg <= {phase[31:30], item.axis_one, item.axis_two, item.centre_x, item.centre_y};
    end

    // ---------------- CORDIC chain ----------------
    logic                 c_vld [NCS+1];
    logic signed [XW-1:0] c_x   [NCS+1];
    logic signed [XW-1:0] c_y   [NCS+1];
    logic signed [ZW-1:0] c_z   [NCS+1];
    logic [CTAG_W-1:0]    c_tag [NCS+1];

    assign c_vld[0] = s0_vld_reg;
    assign c_x[0]   = rer_pkg::CORDIC_START;
    assign c_y[0]   = '0;
    assign c_z[0]   = s0_z_reg;
    assign c_tag[0] = s0_tag_reg;

    for (genvar i = 0; i < NCS; i++)
    begin : g_cordic
        rer_cordic_cell #(.STEP(i), .TAG_W(CTAG_W)) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .vld_in  (c_vld[i]),
            .x_in    (c_x[i]),
            .y_in    (c_y[i]),
            .z_in    (c_z[i]),
            .tag_in  (c_tag[i]),
            .vld_out (c_vld[i+1]),
            .x_out   (c_x[i+1]),
            .y_out   (c_y[i+1]),
            .z_out   (c_z[i+1]),
            .tag_out (c_tag[i+1])
        );
    end

    // ---------------- T1: quadrant fold ----------------
    logic [1:0]            cq;
    logic [15:0]           cr1, cr2;
    logic signed [23:0]    ca, cb;
    logic signed [TW-1:0]  cr, sr, co_next, si_next;
    logic                  t1_vld_reg;
    logic signed [TW-1:0]  t1_c_reg, t1_s_reg;
    logic [15:0]           t1_r1_reg, t1_r2_reg;
    logic signed [23:0]    t1_a_reg, t1_b_reg;

    assign {cq, cr1, cr2, ca, cb} = c_tag[NCS];

    always_comb
    begin
        cr = to_trig(c_x[NCS]);
        sr = to_trig(c_y[NCS]);
        case (cq)
            2'd0:
            begin
                co_next = cr;
                si_next = sr;
            end
            2'd1:
            begin
                co_next = -sr;
                si_next = cr;
            end
            2'd2:
            begin
                co_next = -cr;
                si_next = -sr;
            end
            default:
            begin
                co_next = sr;
                si_next = -cr;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        t1_c_reg  <= co_next;
        t1_s_reg  <= si_next;
        t1_r1_reg <= cr1;
        t1_r2_reg <= cr2;
        t1_a_reg  <= ca;
        t1_b_reg  <= cb;
    end

    // ---------------- T2: first products ----------------
    logic                 t2_vld_reg;
    logic [30:0]          t2_cc_reg, t2_ss_reg;
    logic signed [40:0]   t2_as_reg, t2_bc_reg, t2_ac_reg, t2_bs_reg;
    logic [31:0]          t2_r1sq_reg, t2_r2sq_reg, t2_r1r2_reg;
    logic signed [33:0]   cc_full, ss_full;

    assign cc_full = t1_c_reg * t1_c_reg;
    assign ss_full = t1_s_reg * t1_s_reg;

    always_ff @(posedge clk)
    begin
        t2_cc_reg   <= cc_full[30:0];
        t2_ss_reg   <= ss_full[30:0];
        t2_as_reg   <= t1_a_reg * t1_s_reg;
        t2_bc_reg   <= t1_b_reg * t1_c_reg;
        t2_ac_reg   <= t1_a_reg * t1_c_reg;
        t2_bs_reg   <= t1_b_reg * t1_s_reg;
        t2_r1sq_reg <= t1_r1_reg * t1_r1_reg;
        t2_r2sq_reg <= t1_r2_reg * t1_r2_reg;
        t2_r1r2_reg <= t1_r1_reg * t1_r2_reg;
    end

    // ---------------- T3: scaled products ----------------
    logic                 t3_vld_reg;
    logic [63:0]          t3_pc_reg, t3_ps_reg;
    logic signed [41:0]   t3_v_reg;
    logic signed [57:0]   t3_qa_lo_reg, t3_qa_hi_reg, t3_qb_lo_reg, t3_qb_hi_reg;
    logic [31:0]          t3_r1r2_reg;

    always_ff @(posedge clk)
    begin
        t3_pc_reg    <= 64'(t2_cc_reg) * 64'(t2_r2sq_reg);
        t3_ps_reg    <= 64'(t2_ss_reg) * 64'(t2_r1sq_reg);
        t3_v_reg     <= 42'(t2_as_reg) - 42'(t2_bc_reg);
        t3_qa_lo_reg <= t2_ac_reg * $signed({1'b0, t2_r2sq_reg[15:0]});
        t3_qa_hi_reg <= t2_ac_reg * $signed({1'b0, t2_r2sq_reg[31:16]});
        t3_qb_lo_reg <= t2_bs_reg * $signed({1'b0, t2_r1sq_reg[15:0]});
        t3_qb_hi_reg <= t2_bs_reg * $signed({1'b0, t2_r1sq_reg[31:16]});
        t3_r1r2_reg  <= t2_r1r2_reg;
    end

    // ---------------- T4: sums of partials ----------------
    logic                 t4_vld_reg;
    logic [63:0]          t4_p_reg;
    logic [41:0]          av;
    logic                 t4_big_reg;
    logic [31:0]          t4_av_reg, t4_r1r2_reg;
    logic signed [73:0]   t4_qa_reg, t4_qb_reg;

    assign av = t3_v_reg[41] ? 42'(-t3_v_reg) : 42'(t3_v_reg);

    always_ff @(posedge clk)
    begin
        t4_p_reg    <= t3_pc_reg + t3_ps_reg;
        t4_big_reg  <= |av[41:32];
        t4_av_reg   <= av[31:0];
        t4_qa_reg   <= (74'(t3_qa_hi_reg) <<< 16) + 74'(t3_qa_lo_reg);
        t4_qb_reg   <= (74'(t3_qb_hi_reg) <<< 16) + 74'(t3_qb_lo_reg);
        t4_r1r2_reg <= t3_r1r2_reg;
    end

    // ---------------- T5: offset square, Q sum ----------------
    logic                 t5_vld_reg;
    logic [63:0]          t5_p_reg, t5_av2_reg;
    logic                 t5_big_reg;
    logic signed [74:0]   t5_q_reg;
    logic [31:0]          t5_r1r2_reg;

    always_ff @(posedge clk)
    begin
        t5_p_reg    <= t4_p_reg;
        t5_av2_reg  <= 64'(t4_av_reg) * 64'(t4_av_reg);
        t5_big_reg  <= t4_big_reg;
        t5_q_reg    <= 75'(t4_qa_reg) + 75'(t4_qb_reg);
        t5_r1r2_reg <= t4_r1r2_reg;
    end

    // ---------------- T6: hit test, radicand ----------------
    logic                 t6_vld_reg;
    logic [63:0]          t6_rad_reg;
    logic [STAG_W-1:0]    t6_tag_reg;
    logic                 nohit;
    logic [73:0]          absq;

    assign nohit = (t5_p_reg == 64'd0) | t5_big_reg | (t5_av2_reg > t5_p_reg);
    assign absq  = t5_q_reg[74] ? 74'(-t5_q_reg) : 74'(t5_q_reg);

    always_ff @(posedge clk)
    begin
        t6_rad_reg <= t5_p_reg - t5_av2_reg;
        t6_tag_reg <= {nohit, t5_p_reg, absq, t5_r1r2_reg};
    end

    // ---------------- square root chain ----------------
    logic                          q_vld  [NSQ+1];
    logic [63:0]                   q_x    [NSQ+1];
    logic [rer_pkg::SQRT_REM_W-1:0] q_rem [NSQ+1];
    logic [31:0]                   q_root [NSQ+1];
    logic [STAG_W-1:0]             q_tag  [NSQ+1];

    assign q_vld[0]  = t6_vld_reg;
    assign q_x[0]    = t6_rad_reg;
    assign q_rem[0]  = '0;
    assign q_root[0] = '0;
    assign q_tag[0]  = t6_tag_reg;

    for (genvar i = 0; i < NSQ; i++)
    begin : g_sqrt
        rer_sqrt_cell #(.STEP(NSQ - 1 - i), .TAG_W(STAG_W)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .vld_in   (q_vld[i]),
            .x_in     (q_x[i]),
            .rem_in   (q_rem[i]),
            .root_in  (q_root[i]),
            .tag_in   (q_tag[i]),
            .vld_out  (q_vld[i+1]),
            .x_out    (q_x[i+1]),
            .rem_out  (q_rem[i+1]),
            .root_out (q_root[i+1]),
            .tag_out  (q_tag[i+1])
        );
    end

    // ---------------- T7: root times axis product ----------------
    logic                 sq_nohit;
    logic [63:0]          sq_p;
    logic [73:0]          sq_absq;
    logic [31:0]          sq_r1r2;
    logic                 t7_vld_reg, t7_nohit_reg;
    logic [63:0]          t7_p_reg, t7_m_reg;
    logic [73:0]          t7_absq_reg;

    assign {sq_nohit, sq_p, sq_absq, sq_r1r2} = q_tag[NSQ];

    always_ff @(posedge clk)
    begin
        t7_nohit_reg <= sq_nohit;
        t7_p_reg     <= sq_p;
        t7_m_reg     <= 64'(sq_r1r2) * 64'(q_root[NSQ]);
        t7_absq_reg  <= sq_absq;
    end

    // ---------------- T8: numerator and saturation ----------------
    logic                 t8_vld_reg;
    logic [NW-1:0]        t8_num_reg;
    logic [63:0]          t8_p_reg;
    logic [DTAG_W-1:0]    t8_tag_reg;
    logic [73:0]          dq;
    logic [NW-1:0]        num, lim;

    always_comb
    begin
        if (t7_absq_reg >= 74'(t7_m_reg))
            dq = t7_absq_reg - 74'(t7_m_reg);
        else
            dq = 74'(t7_m_reg) - t7_absq_reg;
        num = NW'(dq) << 15;
        lim = NW'(t7_p_reg) << NDV;
    end

    always_ff @(posedge clk)
    begin
        t8_num_reg <= num;
        t8_p_reg   <= t7_p_reg;
        t8_tag_reg <= {t7_nohit_reg, num >= lim};
    end

    // ---------------- divider chain ----------------
    logic              d_vld [NDV+1];
    logic [NW-1:0]     d_rem [NDV+1];
    logic [63:0]       d_den [NDV+1];
    logic [NDV-1:0]    d_quo [NDV+1];
    logic [DTAG_W-1:0] d_tag [NDV+1];

    assign d_vld[0] = t8_vld_reg;
    assign d_rem[0] = t8_num_reg;
    assign d_den[0] = t8_p_reg;
    assign d_quo[0] = '0;
    assign d_tag[0] = t8_tag_reg;

    for (genvar i = 0; i < NDV; i++)
    begin : g_div
        rer_div_cell #(.STEP(NDV - 1 - i), .TAG_W(DTAG_W)) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .vld_in  (d_vld[i]),
            .rem_in  (d_rem[i]),
            .den_in  (d_den[i]),
            .quo_in  (d_quo[i]),
            .tag_in  (d_tag[i]),
            .vld_out (d_vld[i+1]),
            .rem_out (d_rem[i+1]),
            .den_out (d_den[i+1]),
            .quo_out (d_quo[i+1]),
            .tag_out (d_tag[i+1])
        );
    end

    // ---------------- output stage ----------------
    logic          out_vld_reg;
    rer_pkg::out_t out_reg, out_next;
    logic          fin_nohit, fin_sat;

    assign {fin_nohit, fin_sat} = d_tag[NDV];

    always_comb
    begin
        out_next.hit = ~fin_nohit;
        if (fin_nohit)
            out_next.range = '0;
        else if (fin_sat)
            out_next.range = rer_pkg::RANGE_MAX;
        else
            out_next.range = d_quo[NDV];
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    // Advance the stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t1_vld_reg  <= 1'b0;
            t2_vld_reg  <= 1'b0;
            t3_vld_reg  <= 1'b0;
            t4_vld_reg  <= 1'b0;
            t5_vld_reg  <= 1'b0;
            t6_vld_reg  <= 1'b0;
            t7_vld_reg  <= 1'b0;
            t8_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            t1_vld_reg  <= c_vld[NCS];
            t2_vld_reg  <= t1_vld_reg;
            t3_vld_reg  <= t2_vld_reg;
            t4_vld_reg  <= t3_vld_reg;
            t5_vld_reg  <= t4_vld_reg;
            t6_vld_reg  <= t5_vld_reg;
            t7_vld_reg  <= q_vld[NSQ];
            t8_vld_reg  <= t7_vld_reg;
            out_vld_reg <= d_vld[NDV];
        end
    end

    assign done   = out_vld_reg;
    assign result = out_reg;

    // ---------------- checks ----------------
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("result did not appear at the fixed latency");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.hit) |-> (result.range == 24'd0))
        else $error("miss reported with nonzero range");

    a_sqrt_floor: assert property (@(posedge clk) disable iff (!rst_n)
        q_vld[NSQ] |-> ((66'(q_root[NSQ]) * 66'(q_root[NSQ]) <= 66'(q_x[NSQ])) &&
                        ((66'(q_root[NSQ]) + 66'd1) * (66'(q_root[NSQ]) + 66'd1)
                         > 66'(q_x[NSQ]))))
        else $error("square root chain gave a wrong floor root");

endmodule

@@ design/rer_cordic_cell.sv @@
// One CORDIC rotation step of the sine/cosine chain.
// Depends on rer_pkg for widths and the arctangent table.
module rer_cordic_cell #(
    parameter int STEP  = 0,
    parameter int TAG_W = 1
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   vld_in,
    input  logic signed [rer_pkg::CORDIC_XW-1:0]   x_in,
    input  logic signed [rer_pkg::CORDIC_XW-1:0]   y_in,
    input  logic signed [rer_pkg::CORDIC_ZW-1:0]   z_in,
    input  logic [TAG_W-1:0]                       tag_in,
    output logic                                   vld_out,
    output logic signed [rer_pkg::CORDIC_XW-1:0]   x_out,
    output logic signed [rer_pkg::CORDIC_XW-1:0]   y_out,
    output logic signed [rer_pkg::CORDIC_ZW-1:0]   z_out,
    output logic [TAG_W-1:0]                       tag_out
);

    logic                                 vld_reg;
    logic signed [rer_pkg::CORDIC_XW-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [rer_pkg::CORDIC_ZW-1:0] z_reg, z_next;
    logic [TAG_W-1:0]                     tag_reg;

    // Rotate toward zero residual angle
    always_comb
    begin
        if (!z_in[rer_pkg::CORDIC_ZW-1])
        begin
            x_next = x_in - (y_in >>> STEP);
            y_next = y_in + (x_in >>> STEP);
            z_next = z_in - rer_pkg::atan_val(STEP);
        end
        else
        begin
            x_next = x_in + (y_in >>> STEP);
            y_next = y_in - (x_in >>> STEP);
            z_next = z_in + rer_pkg::atan_val(STEP);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= vld_in;
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        y_reg   <= y_next;
        z_reg   <= z_next;
        tag_reg <= tag_in;
    end

    assign vld_out = vld_reg;
    assign x_out   = x_reg;
    assign y_out   = y_reg;
    assign z_out   = z_reg;
    assign tag_out = tag_reg;

endmodule

@@ design/rer_sqrt_cell.sv @@
// One digit step of the restoring integer square root chain.
// Depends on rer_pkg for the remainder width.
module rer_sqrt_cell #(
    parameter int STEP  = 0,
    parameter int TAG_W = 1
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                vld_in,
    input  logic [63:0]                         x_in,
    input  logic [rer_pkg::SQRT_REM_W-1:0]      rem_in,
    input  logic [31:0]                         root_in,
    input  logic [TAG_W-1:0]                    tag_in,
    output logic                                vld_out,
    output logic [63:0]                         x_out,
    output logic [rer_pkg::SQRT_REM_W-1:0]      rem_out,
    output logic [31:0]                         root_out,
    output logic [TAG_W-1:0]                    tag_out
);

    localparam int CAT_W = rer_pkg::SQRT_REM_W + 2;

    logic                              vld_reg;
    logic [63:0]                       x_reg;
    logic [rer_pkg::SQRT_REM_W-1:0]    rem_reg, rem_next;
    logic [31:0]                       root_reg, root_next;
    logic [TAG_W-1:0]                  tag_reg;
    logic [CAT_W-1:0]                  cat, trial, diff;

    // Bring down two radicand bits and try the next root bit
    always_comb
    begin
        cat   = {rem_in, x_in[2*STEP+1 -: 2]};
        trial = CAT_W'({root_in, 2'b01});
        diff  = cat - trial;
        if (cat >= trial)
        begin
            rem_next  = diff[rer_pkg::SQRT_REM_W-1:0];
            root_next = {root_in[30:0], 1'b1};
        end
        else
        begin
            rem_next  = cat[rer_pkg::SQRT_REM_W-1:0];
            root_next = {root_in[30:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= vld_in;
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_in;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        tag_reg  <= tag_in;
    end

    assign vld_out  = vld_reg;
    assign x_out    = x_reg;
    assign rem_out  = rem_reg;
    assign root_out = root_reg;
    assign tag_out  = tag_reg;

endmodule

@@ design/rer_div_cell.sv @@
// One quotient bit of the restoring divider chain.
// Depends on rer_pkg for the numerator width.
module rer_div_cell #(
    parameter int STEP  = 0,
    parameter int TAG_W = 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          vld_in,
    input  logic [rer_pkg::NUM_W-1:0]     rem_in,
    input  logic [63:0]                   den_in,
    input  logic [rer_pkg::DIV_STEPS-1:0] quo_in,
    input  logic [TAG_W-1:0]              tag_in,
    output logic                          vld_out,
    output logic [rer_pkg::NUM_W-1:0]     rem_out,
    output logic [63:0]                   den_out,
    output logic [rer_pkg::DIV_STEPS-1:0] quo_out,
    output logic [TAG_W-1:0]              tag_out
);

    logic                          vld_reg;
    logic [rer_pkg::NUM_W-1:0]     rem_reg, rem_next, dsh;
    logic [63:0]                   den_reg;
    logic [rer_pkg::DIV_STEPS-1:0] quo_reg, quo_next;
    logic [TAG_W-1:0]              tag_reg;

    // Subtract the shifted divisor where it fits
    always_comb
    begin
        dsh      = rer_pkg::NUM_W'(den_in) << STEP;
        rem_next = rem_in;
        quo_next = quo_in;
        if (rem_in >= dsh)
        begin
            rem_next       = rem_in - dsh;
            quo_next[STEP] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= vld_in;
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_in;
        quo_reg <= quo_next;
        tag_reg <= tag_in;
    end

    assign vld_out = vld_reg;
    assign rem_out = rem_reg;
    assign den_out = den_reg;
    assign quo_out = quo_reg;
    assign tag_out = tag_reg;

endmodule

@@ dv/testbench.sv @@
// Testbench for ray_ellipse_range_unit: directed and random beam/ellipse items,
// each checked against an in-bench integer predictor. Depends on rer_pkg and the unit.
`timescale 1ns / 1ps

module testbench;

    localparam int  RANDOM_ITEMS = 1700;
    localparam int  DRAIN_CYCLES = 120;
    localparam longint CYCLE_LIMIT = 2000000;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    rer_pkg::in_t  item;
    logic done;
    rer_pkg::out_t result;

    rer_pkg::in_t  pending_items[$];
    rer_pkg::out_t expected_ranges[$];
    int   gap_left;
    logic accepted;
    bit   failed;
    bit   stimulus_done;
    longint cycle_count;

    localparam longint ATAN_TAB[24] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };

    ray_ellipse_range_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .done   (done),
        .result (result)
    );

    // Clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Round a CORDIC output to 2^15 scale and clamp
    function automatic longint trig_round(longint v);
        longint r;
        r = (v + 64'sd16384) >>> 15;
        if (r > 32768) r = 32768;
        if (r < -32768) r = -32768;
        return r;
    endfunction

    // Floor square root of a 64-bit value
    function automatic logic [63:0] floor_sqrt(logic [63:0] x);
        logic [63:0] res;
        logic [63:0] bitv;
        res = '0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (x >= res + bitv)
            begin
                x = x - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Expected hit and range for one beam/ellipse pair
    function automatic rer_pkg::out_t predict_range(rer_pkg::in_t it);
        rer_pkg::out_t o;
        logic [31:0] phase;
        logic [1:0]  quad;
        longint x, y, z, xs, ys, cr, sr, c, s, a, b, v;
        logic [63:0] r1, r2, r1sq, r2sq, p, av, g, m;
        logic signed [127:0] q;
        logic [127:0] qa, num;
        phase = {it.beam_angle, 16'h0000};
        quad = phase[31:30];
        z = longint'({2'b00, phase[29:0]});
        x = 652032874;
        y = 0;
        for (int i = 0; i < 24; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0)
            begin
                x = x - ys; y = y + xs; z = z - ATAN_TAB[i];
            end
            else
            begin
                x = x + ys; y = y - xs; z = z + ATAN_TAB[i];
            end
        end
        cr = trig_round(x);
        sr = trig_round(y);
        case (quad)
            2'd0: begin c = cr;  s = sr;  end
            2'd1: begin c = -sr; s = cr;  end
            2'd2: begin c = -cr; s = -sr; end
            default: begin c = sr; s = -cr; end
        endcase
        r1 = it.axis_one;
        r2 = it.axis_two;
        a = it.centre_x;
        b = it.centre_y;
        r1sq = r1 * r1;
        r2sq = r2 * r2;
        p = 64'(c * c) * r2sq + 64'(s * s) * r1sq;
        v = a * s - b * c;
        av = (v < 0) ? 64'(-v) : 64'(v);
        o.hit = 1'b0;
        o.range = '0;
        if (p == 0 || av > 64'hFFFF_FFFF || av * av > p)
            return o;
        g = floor_sqrt(p - av * av);
        m = (r1 * r2) * g;
        q = 128'(a * c) * $signed({64'd0, r2sq}) + 128'(b * s) * $signed({64'd0, r1sq});
        qa = (q < 0) ? 128'(-q) : 128'(q);
        num = (qa < {64'd0, m}) ? ({64'd0, m} - qa) : (qa - {64'd0, m});
        num = num << 15;
        o.hit = 1'b1;
        if (num >= ({64'd0, p} << 24))
            o.range = rer_pkg::RANGE_MAX;
        else
            o.range = 24'(num / {64'd0, p});
        return o;
    endfunction

    function automatic rer_pkg::in_t make_item(logic [15:0] ang, logic [15:0] r1,
                                               logic [15:0] r2, logic [23:0] cx,
                                               logic [23:0] cy);
        rer_pkg::in_t it;
        it.beam_angle = ang;
        it.axis_one = r1;
        it.axis_two = r2;
        it.centre_x = cx;
        it.centre_y = cy;
        return it;
    endfunction

    // Random item: mostly ellipses placed along the beam, some free noise
    function automatic rer_pkg::in_t random_item();
        rer_pkg::in_t it;
        real th, d, jx, jy;
        int  mode;
        int  span;
        mode = $urandom_range(0, 9);
        it.beam_angle = 16'($urandom);
        span = $urandom_range(1, 16);
        it.axis_one = 16'($urandom_range(1, (1 << span) - 1));
        span = $urandom_range(1, 16);
        it.axis_two = 16'($urandom_range(1, (1 << span) - 1));
        if (mode < 7)
        begin
            th = real'(it.beam_angle) * 6.283185307179586 / 65536.0;
            if ($urandom_range(0, 1) == 1) th = th + 3.141592653589793;
            d = real'($urandom_range(0, 1 << $urandom_range(4, 23)));
            jx = (real'($urandom_range(0, 2000)) - 1000.0) / 1000.0 * real'(it.axis_one);
            jy = (real'($urandom_range(0, 2000)) - 1000.0) / 1000.0 * real'(it.axis_two);
            jx = d * $cos(th) + jx;
            jy = d * $sin(th) + jy;
            if (jx > 8388607.0) jx = 8388607.0;
            if (jx < -8388608.0) jx = -8388608.0;
            if (jy > 8388607.0) jy = 8388607.0;
            if (jy < -8388608.0) jy = -8388608.0;
            it.centre_x = 24'($rtoi(jx));
            it.centre_y = 24'($rtoi(jy));
        end
        else
        begin
            it.centre_x = 24'($urandom);
            it.centre_y = 24'($urandom);
            if (mode == 9) it.axis_one = 16'($urandom_range(1, 65535));
        end
        return it;
    endfunction

    // Append one item to the pending queue
    task automatic add_item(rer_pkg::in_t it);
        pending_items.insert(pending_items.size(), it);
    endtask

    // Stimulus: reset, directed corners, then random items
    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        item = '0;
        gap_left = 0;
        failed = 1'b0;
        stimulus_done = 1'b0;
        // quadrant axes, one direction each
        add_item(make_item(16'h0000, 16'd160, 16'd80, 24'sd1600, 24'sd0));
        add_item(make_item(16'h4000, 16'd160, 16'd80, 24'sd0, 24'sd1600));
        add_item(make_item(16'h8000, 16'd160, 16'd80, 24'sd1600, 24'sd0));
        add_item(make_item(16'hC000, 16'd160, 16'd80, 24'sd0, -24'sd1600));
        // vertical beam near cosine zero
        add_item(make_item(16'h3FFF, 16'd50, 16'd900, 24'sd3, 24'sd5000));
        add_item(make_item(16'h4001, 16'd50, 16'd900, -24'sd3, -24'sd5000));
        // miss: negative discriminant
        add_item(make_item(16'h0000, 16'd10, 16'd10, 24'sd0, 24'sd5000));
        // origin inside the ellipse
        add_item(make_item(16'h1234, 16'd400, 16'd300, 24'sd20, -24'sd10));
        // smallest and largest axes
        add_item(make_item(16'h2000, 16'd1, 16'd1, 24'sd0, 24'sd0));
        add_item(make_item(16'hFFFF, 16'hFFFF, 16'hFFFF, 24'sd0, 24'sd0));
        add_item(make_item(16'h6000, 16'hFFFF, 16'd1, -24'sd8388608, 24'sd8388607));
        // centre extremes, far ranges
        add_item(make_item(16'h0000, 16'd1, 16'hFFFF, 24'sd8388607, 24'sd0));
        add_item(make_item(16'h8000, 16'd1, 16'hFFFF, -24'sd8388608, 24'sd0));
        add_item(make_item(16'h2000, 16'hFFFF, 16'hFFFF, 24'sd8388607, 24'sd8388607));
        add_item(make_item(16'hA000, 16'hFFFF, 16'hFFFF, -24'sd8388608, -24'sd8388608));
        add_item(make_item(16'h5555, 16'hAAAA, 16'h5555, 24'h555555, 24'hAAAAAA));
        add_item(make_item(16'hAAAA, 16'h5555, 16'hAAAA, 24'hAAAAAA, 24'h555555));
        // tangent-ish grazing line
        add_item(make_item(16'h0000, 16'd100, 16'd100, 24'sd3000, 24'sd100));
        for (int n = 0; n < RANDOM_ITEMS; n++)
            add_item(random_item());
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        wait (pending_items.size() == 0 && !start);
        wait (expected_ranges.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        stimulus_done = 1'b1;
    end

    // Pick the idle time before the next transfer
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    // Driver: hold the item until transfer, then idle or advance
    always @(negedge clk)
    begin
        if (rst_n && (!start || accepted))
        begin
            if (gap_left > 0)
            begin
                start <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (pending_items.size() > 0)
            begin
                item <= pending_items.pop_front();
                start <= 1'b1;
                gap_left <= pick_gap();
            end
            else
                start <= 1'b0;
        end
    end

    // Monitor: predict on input transfer, check each result
    always @(posedge clk or negedge rst_n)
    begin
        rer_pkg::out_t want;
        if (!rst_n)
            accepted <= 1'b0;
        else
        begin
            accepted <= start && !busy;
            if (start && !busy)
                expected_ranges.insert(expected_ranges.size(), predict_range(item));
            if (done)
            begin
                if (expected_ranges.size() == 0)
                begin
                    $display("%0t: unexpected result hit=%0d range=%0d",
                             $time, result.hit, result.range);
                    failed = 1'b1;
                end
                else
                begin
                    want = expected_ranges.pop_front();
                    if (result.hit !== want.hit)
                    begin
                        $display("%0t: hit expected %0d actual %0d",
                                 $time, want.hit, result.hit);
                        failed = 1'b1;
                    end
                    if (result.range !== want.range)
                    begin
                        $display("%0t: range expected %0d actual %0d",
                                 $time, want.range, result.range);
                        failed = 1'b1;
                    end
                end
            end
        end
    end

    // Final verdict or timeout
    initial
    begin
        cycle_count = 0;
        while (!stimulus_done && cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count = cycle_count + 1;
        end
        if (!stimulus_done)
            $display("FAIL");
        else if (!failed && expected_ranges.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
